[design/opha_pkg.sv]
// Package for the object pool handle allocator: request and result codes,
// field widths and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package opha_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned HANDLE_W = 6;
  localparam int unsigned STATUS_W = 2;

  // Request kinds; the fourth code is unused and produces an ok result.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC     = 2'd0,
    FUNC_TRY_ALLOC = 2'd1,
    FUNC_DEALLOC   = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic capture;  // latch request and issue memory reads
    logic commit;   // update state and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_status_t;

endpackage

[design/opha_req_if.sv]
// Request channel interface: valid/ready handshake with func and handle_in.
// Depends on opha_pkg.
`timescale 1ns / 1ps

interface opha_req_if;
  import opha_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [HANDLE_W-1:0] handle_in;

  modport source (output valid, output func, output handle_in, input ready);
  modport sink   (input valid, input func, input handle_in, output ready);
endinterface

[design/opha_rsp_if.sv]
// Result channel interface: valid/ready handshake with handle_out and status.
// Depends on opha_pkg.
`timescale 1ns / 1ps

interface opha_rsp_if;
  import opha_pkg::*;

  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] handle_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output handle_out, output status, input ready);
  modport sink   (input valid, input handle_out, input status, output ready);
endinterface

[design/opha_ctrl.sv]
// Controller for the handle allocator: two-state sequencer that captures a
// request, then commits it once the result register is free. Uses opha_pkg.
`timescale 1ns / 1ps

module opha_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  opha_pkg::dp_status_t dp_status_i,
  output opha_pkg::dp_cmd_t    dp_cmd_o
);
  import opha_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTRL_IDLE: begin
        if (req_valid_i) state_d = CTRL_EXEC;
      end
      CTRL_EXEC: begin
        if (dp_status_i.out_free) state_d = CTRL_IDLE;
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o      = 1'b0;
    dp_cmd_o.capture = 1'b0;
    dp_cmd_o.commit  = 1'b0;
    unique case (state_q)
      CTRL_IDLE: begin
        req_ready_o      = 1'b1;
        dp_cmd_o.capture = req_valid_i;
      end
      CTRL_EXEC: begin
        dp_cmd_o.commit = dp_status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

[design/opha_dp.sv]
// Datapath for the handle allocator: allocated bitmap, free-handle FIFO
// memory, counters and the result register. Uses opha_pkg.
`timescale 1ns / 1ps

module opha_dp #(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  opha_pkg::dp_cmd_t             dp_cmd_i,
  output opha_pkg::dp_status_t          dp_status_o,
  input  logic [opha_pkg::FUNC_W-1:0]   func_i,
  input  logic [opha_pkg::HANDLE_W-1:0] handle_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [opha_pkg::HANDLE_W-1:0] handle_out_o,
  output logic [opha_pkg::STATUS_W-1:0] status_o
);
  import opha_pkg::*;

  localparam int unsigned HW   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned CW   = $clog2(POOL_SIZE + 1);
  localparam int unsigned CMPW = (CW > HANDLE_W) ? CW : HANDLE_W;

  // Memories: no reset. Bitmap entries at or above created_q were never
  // written and are treated as clear.
  logic          map_mem [POOL_SIZE];
  logic [HW-1:0] fq_mem  [POOL_SIZE];

  logic [HW-1:0] head_q, head_d;
  logic [HW-1:0] tail_q, tail_d;
  logic [CW-1:0] qcount_q, qcount_d;
  logic [CW-1:0] created_q, created_d;

  // Captured request and registered memory reads.
  logic [FUNC_W-1:0] func_q;
  logic [HW-1:0]     hin_addr_q;
  logic              hin_live_q;
  logic              map_rd_q;
  logic [HW-1:0]     fq_rd_q;

  logic                out_valid_q;
  logic [HANDLE_W-1:0] handle_out_q;
  logic [STATUS_W-1:0] status_q;

  logic [CMPW-1:0] hin_ext;
  logic [HW-1:0]   hin_addr;
  logic            hin_live;

  logic          map_we, map_wd;
  logic [HW-1:0] map_wa;
  logic          fq_we;
  logic [HW-1:0] handle_sel;
  status_e       status_sel;

  assign hin_ext  = CMPW'(handle_in_i);
  assign hin_addr = hin_ext[HW-1:0];
  assign hin_live = hin_ext < CMPW'(created_q);

  assign dp_status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      func_q     <= func_i;
      hin_addr_q <= hin_addr;
      hin_live_q <= hin_live;
      map_rd_q   <= map_mem[hin_addr];
      fq_rd_q    <= fq_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
  end

  always_ff @(posedge clk_i) begin
    if (fq_we) fq_mem[tail_q] <= hin_addr_q;
  end

  // Commit: pop or create on allocate, push on a valid release.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    qcount_d   = qcount_q;
    created_d  = created_q;
    map_we     = 1'b0;
    map_wa     = hin_addr_q;
    map_wd     = 1'b0;
    fq_we      = 1'b0;
    handle_sel = '0;
    status_sel = ST_OK;
    if (dp_cmd_i.commit) begin
      case (func_q)
        FUNC_ALLOC, FUNC_TRY_ALLOC: begin
          if (qcount_q != '0) begin
            handle_sel = fq_rd_q;
            map_we     = 1'b1;
            map_wa     = fq_rd_q;
            map_wd     = 1'b1;
            head_d     = (head_q == HW'(POOL_SIZE - 1)) ? '0 : head_q + 1'b1;
            qcount_d   = qcount_q - 1'b1;
          end else if (func_q == FUNC_TRY_ALLOC) begin
            status_sel = ST_EMPTY;
          end else if (created_q < CW'(POOL_SIZE)) begin
            handle_sel = created_q[HW-1:0];
            map_we     = 1'b1;
            map_wa     = created_q[HW-1:0];
            map_wd     = 1'b1;
            created_d  = created_q + 1'b1;
          end else begin
            status_sel = ST_EXHAUSTED;
          end
        end
        FUNC_DEALLOC: begin
          if (hin_live_q && map_rd_q) begin
            map_we = 1'b1;
            map_wd = 1'b0;
            if (qcount_q < CW'(POOL_SIZE)) begin
              fq_we    = 1'b1;
              tail_d   = (tail_q == HW'(POOL_SIZE - 1)) ? '0 : tail_q + 1'b1;
              qcount_d = qcount_q + 1'b1;
            end
          end else begin
            status_sel = ST_NOT_ALLOC;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      qcount_q    <= '0;
      created_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      qcount_q  <= qcount_d;
      created_q <= created_d;
      if (dp_cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.commit) begin
      handle_out_q <= HANDLE_W'(handle_sel);
      status_q     <= status_sel;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign handle_out_o = handle_out_q;
  assign status_o     = status_q;

endmodule

[design/object_pool_handle_allocator.sv]
// Object pool handle allocator top level: controller plus datapath.
// Depends on opha_pkg, opha_req_if, opha_rsp_if, opha_ctrl and opha_dp.
//
// Usage:
//   req_i carries one request per handshake: func selects allocate,
//   try-allocate or deallocate, handle_in names the handle to release.
//   rsp_o returns exactly one result per request, in order: handle_out is
//   the granted handle (zero otherwise) and status reports ok, no freed
//   handle, handle not allocated or pool exhausted.
// Timing:
//   A request is captured in the idle state, in which the bitmap entry and the
//   FIFO head are read from memory into registers; the execute state then
//   commits it into the result register once that register is free, which
//   raises rsp_o.valid. A new request is accepted only after the last one
//   has committed, as the bitmap and free-FIFO memories are read into
//   registers ahead of the update.
// Reset:
//   Counters and FIFO pointers clear; the bitmap counts as all clear since
//   only entries below the creation counter are consulted. No clearing
//   pass, so requests are taken from the first cycle after reset.
// Backpressure:
//   A finished result waits in the result register while the next request
//   is accepted; a second request waits in the datapath until rsp_o.ready.
`timescale 1ns / 1ps

module object_pool_handle_allocator #(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  opha_req_if.sink          req_i,
  opha_rsp_if.source        rsp_o
);
  import opha_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequence each request: capture, then commit when the output can take it.
  opha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  // Hold the pool state and the result register.
  opha_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dp_cmd_i     (dp_cmd),
    .dp_status_o  (dp_status),
    .func_i       (req_i.func),
    .handle_in_i  (req_i.handle_in),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .handle_out_o (rsp_o.handle_out),
    .status_o     (rsp_o.status)
  );

endmodule
